@@ design/page_frame_buffer_manager_defines.svh @@
// Assertion macros for the page frame buffer manager top level.
// No dependencies.
`ifndef PAGE_FRAME_BUFFER_MANAGER_DEFINES_SVH
`define PAGE_FRAME_BUFFER_MANAGER_DEFINES_SVH
`ifndef SYNTHESIS
`define PFBM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PFBM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFBM_ASSERT(label, clk, rst, prop, msg)
`define PFBM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ design/pfbm_pkg.sv @@
// Types and constants of the page frame buffer manager.
// No dependencies.
package pfbm_pkg;
  localparam logic [2:0] OP_REQUEST = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_FIX     = 3'd3;
  localparam logic [2:0] OP_UNFIX   = 3'd4;
  localparam logic [2:0] OP_DIRTY   = 3'd5;
  localparam logic [2:0] OP_FLUSH   = 3'd6;
  localparam logic [2:0] OP_IGNORED = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_NOVICT  = 2'd2;
  localparam logic [1:0] ST_FIXRULE = 2'd3;

  localparam logic [0:0] REG_FRAME_LIMIT = 1'd0;
  localparam logic [0:0] REG_PROBE_SEED  = 1'd1;

  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam logic [15:0] SEED_RESET = 16'd44257;
  localparam logic [4:0]  LIMIT_RESET = 5'd16;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] page_id;
    logic [63:0] new_page_id;
    logic        dirty_flag;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  frame_index;
    logic        hit;
    logic        load_request;
    logic        save_request;
    logic [63:0] save_page_id;
    logic        drop_request;
    logic        last;
  } rsp_t;

  // Probe unit control from the sequencer.
  typedef struct packed {
    logic        step;
  } probe_ctl_t;
endpackage

@@ design/pfbm_if.sv @@
// Valid/ready channel carrying one payload.
// Depends on nothing but the payload type given as parameter.
interface pfbm_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/pfbm_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module pfbm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ design/pfbm_probe.sv @@
// Victim probe generator: LFSR and reduction of its value modulo the limit.
// Depends on pfbm_pkg.
module pfbm_probe #(
  parameter int FRAMES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     seed_we,
  input  logic [15:0]              seed,
  input  pfbm_pkg::probe_ctl_t     ctl,
  input  logic [6:0]               limit,
  output logic                     done,
  output logic [$clog2(FRAMES)-1:0] slot
);
  import pfbm_pkg::*;
  localparam int IW = $clog2(FRAMES);

  logic [15:0] lfsr;
  logic [15:0] lfsr_next;
  logic [15:0] rem;
  logic [22:0] sub;
  logic [4:0]  bitn;
  logic        busy;

  always_comb begin
    lfsr_next = (lfsr == 16'd0) ? 16'd1 : lfsr;
    lfsr_next = lfsr_next[0] ? ((lfsr_next >> 1) ^ LFSR_TAPS) : (lfsr_next >> 1);
  end

  // Restoring remainder, one bit per cycle while no seed write comes in.
  assign sub = {rem[15:0], lfsr[bitn[3:0]]} - {16'd0, limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= SEED_RESET;
      busy <= 1'b0;
      bitn <= 5'd0;
      rem  <= 16'd0;
    end else if (seed_we) begin
      lfsr <= (seed == 16'd0) ? 16'd1 : seed;
    end else if (ctl.step) begin
      lfsr <= lfsr_next;
      busy <= 1'b1;
      bitn <= 5'd15;
      rem  <= 16'd0;
    end else if (busy) begin
      if (!sub[22]) begin
        rem <= sub[15:0];
      end else begin
        rem <= {rem[14:0], lfsr[bitn[3:0]]};
      end
      if (bitn == 5'd0) begin
        busy <= 1'b0;
      end
      bitn <= bitn - 5'd1;
    end
  end

  assign done = !busy;
  assign slot = rem[IW-1:0];
endmodule

@@ design/page_frame_buffer_manager.sv @@
// Top level of the page frame buffer manager: sequencer and frame state.
// Depends on pfbm_pkg, pfbm_if, pfbm_ram, pfbm_probe and the defines header.
//
//  channel | direction | payload
//  req     | in        | operation, page_id, new_page_id, dirty_flag
//  rsp     | out       | status, frame_index, hit, requests, save_page_id, last
//  cfg     | in        | frame_limit (0), probe_seed (1)
//
// A lookup reads one tag per cycle and scans every frame before a hit or
// absent page gives its result; a miss goes on to a fill. Each eviction
// probe waits for a bit-serial remainder, up to MAX_PROBES probes. Flush
// scans every frame and gives one result per dirty frame, or one empty
// result if none is dirty, and holds while a result waits at the output.
// Reset is synchronous; one request is worked on at a time and a stalled
// result holds the sequencer.
module page_frame_buffer_manager #(
  parameter int FRAMES = 16,
  parameter int MAX_PROBES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  pfbm_if.sink        req,
  pfbm_if.source      rsp
);
  import pfbm_pkg::*;
  `include "page_frame_buffer_manager_defines.svh"

  localparam int IW = $clog2(FRAMES);
  localparam int PW = $clog2(MAX_PROBES + 1);
  localparam int UW = $clog2(FRAMES + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_PSTEP  = 4'd3;
  localparam logic [3:0] S_PWAIT  = 4'd4;
  localparam logic [3:0] S_PREAD  = 4'd5;
  localparam logic [3:0] S_PCHK   = 4'd6;
  localparam logic [3:0] S_FILL   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;
  localparam logic [3:0] S_FLUSH  = 4'd9;
  localparam logic [3:0] S_FOUT   = 4'd10;

  logic [3:0]        state;
  req_t              cur;
  logic [IW:0]       idx;
  logic [IW:0]       ridx;
  logic              found;
  logic [IW-1:0]     fslot;
  logic [PW-1:0]     probes;
  logic [4:0]        frame_limit;
  logic [UW-1:0]     frames_used;
  logic              rsp_valid;
  rsp_t              rsp_data;

  logic [FRAMES-1:0] fvalid;
  logic [FRAMES-1:0] mark;
  logic [FRAMES-1:0] dirty;
  logic [7:0]        fixc [FRAMES];

  logic              tag_we;
  logic [IW-1:0]     tag_addr;
  logic [63:0]       tag_wdata;
  logic [63:0]       tag_rdata;
  logic [63:0]       key;
  logic [6:0]        eff_limit;
  logic              pdone;
  logic [IW-1:0]     pslot;
  probe_ctl_t        pctl;

  pfbm_ram #(.WIDTH(64), .DEPTH(FRAMES)) u_tags (
    .clk(clk), .we(tag_we), .addr(tag_addr), .wdata(tag_wdata), .rdata(tag_rdata)
  );

  always_comb begin
    if (frame_limit == 5'd0) begin
      eff_limit = 7'd1;
    end else if (7'(frame_limit) > 7'(FRAMES)) begin
      eff_limit = 7'(FRAMES);
    end else begin
      eff_limit = 7'(frame_limit);
    end
  end

  pfbm_probe #(.FRAMES(FRAMES)) u_probe (
    .clk(clk), .rst(rst), .seed_we(cfg_we && cfg_index == REG_PROBE_SEED),
    .seed(cfg_data), .ctl(pctl), .limit(eff_limit), .done(pdone), .slot(pslot)
  );

  assign key = (cur.operation == OP_CREATE) ? cur.new_page_id : cur.page_id;
  assign req.ready = (state == S_IDLE) && !rsp_valid;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_comb begin
    pctl = '0;
    pctl.step = (state == S_PSTEP);
    tag_we = 1'b0;
    tag_wdata = key;
    tag_addr = idx[IW-1:0];
    // A stalled flush keeps reading the slot it is about to check.
    if (state == S_FLUSH && rsp_valid && !rsp.ready) begin
      tag_addr = ridx[IW-1:0];
    end
    if (state == S_PREAD || state == S_PCHK) begin
      tag_addr = pslot;
    end
    if (state == S_FILL) begin
      tag_addr = fslot;
      tag_we = 1'b1;
    end
  end

  // Lowest free slot.
  logic [IW-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (!fvalid[i]) begin
        free_slot = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      fvalid <= '0;
      mark <= '0;
      dirty <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        fixc[i] <= 8'd0;
      end
      frames_used <= '0;
      frame_limit <= LIMIT_RESET;
    end else begin
      if (cfg_we && cfg_index == REG_FRAME_LIMIT) begin
        frame_limit <= cfg_data[4:0];
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.data;
            idx <= '0;
            ridx <= '0;
            found <= 1'b0;
            probes <= '0;
            rsp_data <= '0;
            state <= (req.data.operation == OP_FLUSH) ? S_FLUSH : S_SCAN;
            if (req.data.operation == OP_IGNORED) begin
              rsp_data.last <= 1'b1;
              rsp_valid <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_SCAN: begin
          // Read data arrives in the cycle after the address.
          if (idx != '0) begin
            if (fvalid[ridx[IW-1:0]] && tag_rdata == key && !found) begin
              found <= 1'b1;
              fslot <= ridx[IW-1:0];
            end
          end
          ridx <= idx;
          if (idx == (IW+1)'(FRAMES)) begin
            state <= S_DECIDE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DECIDE: begin
          rsp_data.last <= 1'b1;
          rsp_data.frame_index <= 4'(fslot);
          rsp_data.hit <= found;
          state <= S_OUT;
          if (!found) begin
            rsp_data.frame_index <= '0;
            if (cur.operation == OP_REQUEST || cur.operation == OP_CREATE) begin
              if (frames_used < UW'(eff_limit) && !(&fvalid)) begin
                fslot <= free_slot;
                frames_used <= frames_used + 1'b1;
                state <= S_FILL;
              end else begin
                state <= S_PSTEP;
              end
            end else begin
              rsp_data.status <= ST_ABSENT;
            end
          end else begin
            case (cur.operation)
              OP_REQUEST: begin
                if (fixc[fslot] != 8'd255) begin
                  fixc[fslot] <= fixc[fslot] + 8'd1;
                end
                mark[fslot] <= 1'b1;
              end
              OP_CREATE: begin
                fixc[fslot] <= 8'd1;
                mark[fslot] <= 1'b1;
                dirty[fslot] <= 1'b1;
              end
              OP_DELETE: begin
                if (fixc[fslot] != 8'd0) begin
                  rsp_data.status <= ST_FIXRULE;
                end else begin
                  fvalid[fslot] <= 1'b0;
                  mark[fslot] <= 1'b0;
                  dirty[fslot] <= 1'b0;
                  rsp_data.drop_request <= 1'b1;
                  if (frames_used != '0) begin
                    frames_used <= frames_used - 1'b1;
                  end
                end
              end
              OP_FIX: begin
                if (fixc[fslot] != 8'd0) begin
                  rsp_data.status <= ST_FIXRULE;
                end else begin
                  fixc[fslot] <= 8'd1;
                  mark[fslot] <= 1'b1;
                end
              end
              OP_UNFIX: begin
                if (fixc[fslot] != 8'd1) begin
                  rsp_data.status <= ST_FIXRULE;
                end else begin
                  fixc[fslot] <= 8'd0;
                  if (cur.dirty_flag) begin
                    dirty[fslot] <= 1'b1;
                  end
                end
              end
              OP_DIRTY: begin
                dirty[fslot] <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_PSTEP: begin
          if (probes == PW'(MAX_PROBES)) begin
            rsp_data.status <= ST_NOVICT;
            rsp_data.frame_index <= '0;
            state <= S_OUT;
          end else begin
            probes <= probes + 1'b1;
            state <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          if (pdone) begin
            state <= S_PREAD;
          end
        end
        S_PREAD: begin
          state <= S_PCHK;
        end
        S_PCHK: begin
          state <= S_PSTEP;
          if (fvalid[pslot] && fixc[pslot] == 8'd0) begin
            if (mark[pslot]) begin
              mark[pslot] <= 1'b0;
            end else begin
              fslot <= pslot;
              if (dirty[pslot]) begin
                rsp_data.save_request <= 1'b1;
                rsp_data.save_page_id <= tag_rdata;
              end
              state <= S_FILL;
            end
          end
        end
        S_FILL: begin
          fvalid[fslot] <= 1'b1;
          fixc[fslot] <= 8'd1;
          mark[fslot] <= 1'b1;
          dirty[fslot] <= (cur.operation == OP_CREATE);
          rsp_data.status <= ST_OK;
          rsp_data.frame_index <= 4'(fslot);
          rsp_data.load_request <= (cur.operation == OP_REQUEST);
          state <= S_OUT;
        end
        S_OUT: begin
          rsp_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_FLUSH: begin
          if (!rsp_valid || rsp.ready) begin
            if (idx != '0 && fvalid[ridx[IW-1:0]] && dirty[ridx[IW-1:0]]) begin
              found <= 1'b1;
              rsp_data <= '0;
              rsp_data.frame_index <= 4'(ridx[IW-1:0]);
              rsp_data.save_request <= 1'b1;
              rsp_data.save_page_id <= tag_rdata;
              state <= S_FOUT;
            end else if (idx == (IW+1)'(FRAMES)) begin
              if (!found) begin
                rsp_data <= '0;
                rsp_data.last <= 1'b1;
                rsp_valid <= 1'b1;
              end
              state <= S_IDLE;
            end else begin
              ridx <= idx;
              idx <= idx + 1'b1;
            end
          end
        end
        S_FOUT: begin
          // Look ahead at the later frames to learn whether this result is the last.
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_data.last <= 1'b1;
            for (int j = 0; j < FRAMES; j++) begin
              if (j > int'(ridx[IW-1:0]) && fvalid[j] && dirty[j]) begin
                rsp_data.last <= 1'b0;
              end
            end
            if (idx == (IW+1)'(FRAMES) && ridx == idx) begin
              state <= S_IDLE;
            end else begin
              ridx <= idx;
              if (idx != (IW+1)'(FRAMES)) begin
                idx <= idx + 1'b1;
              end
              state <= (idx == (IW+1)'(FRAMES)) ? S_IDLE : S_FLUSH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PFBM_ASSERT(a_busy_not_ready, clk, rst, (state != S_IDLE) |-> !req.ready,
    "input taken while busy")
  `PFBM_ASSERT(a_used_bound, clk, rst, frames_used <= UW'(FRAMES),
    "frames_used out of range")
  `PFBM_ASSERT(a_hold, clk, rst, (rsp.valid && !rsp.ready) |=> rsp.valid,
    "result dropped while stalled")
endmodule

@@ bench/tb.sv @@
// Self-checking bench for page_frame_buffer_manager: random and directed page
// operations, with a frame pool predictor and an in-order result checker.
// Depends on pfbm_pkg, pfbm_if and page_frame_buffer_manager from the design folder.
module tb;
  import pfbm_pkg::*;

  localparam int NFRAMES = 16;
  localparam int PROBE_LIMIT = 64;
  localparam int STALL_LIMIT = 6000;
  localparam int NPOOL = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  pfbm_if #(.T(req_t)) req_ch (clk);
  pfbm_if #(.T(rsp_t)) rsp_ch (clk);

  page_frame_buffer_manager dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch), .rsp(rsp_ch)
  );

  always #6 clk = ~clk;

  // Predicted frame pool.
  logic [63:0] tag_q [NFRAMES];
  logic        valid_q [NFRAMES];
  logic [7:0]  fixcnt_q [NFRAMES];
  logic        mark_q [NFRAMES];
  logic        dirty_q [NFRAMES];
  int          used_frames;
  logic [15:0] lfsr_q;
  logic [4:0]  limit_reg;

  req_t        pending_reqs [$];
  rsp_t        expected_rsps [$];
  logic [63:0] id_pool [NPOOL];
  int          failures = 0;
  int          stall_cycles = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          quiet = 1'b0;
  int          hold_token = 0;
  int          hold_seen = 0;

  function automatic int pool_limit();
    if (limit_reg == 0) return 1;
    if (limit_reg > NFRAMES) return NFRAMES;
    return int'(limit_reg);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic int lookup_page(logic [63:0] id);
    for (int i = 0; i < NFRAMES; i++)
      if (valid_q[i] && tag_q[i] == id) return i;
    return -1;
  endfunction

  // Picks a free frame or runs the second chance search; -1 means no victim.
  function automatic int claim_frame(output logic sv, output logic [63:0] sid);
    int lim;
    int s;
    lim = pool_limit();
    sv = 1'b0;
    sid = '0;
    if (used_frames < lim)
      for (int i = 0; i < NFRAMES; i++)
        if (!valid_q[i]) begin
          used_frames++;
          return i;
        end
    for (int p = 0; p < PROBE_LIMIT; p++) begin
      if (lfsr_q == 0) lfsr_q = 16'd1;
      lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
      s = int'(lfsr_q) % lim;
      if (!valid_q[s] || fixcnt_q[s] != 0) continue;
      if (mark_q[s]) begin
        mark_q[s] = 1'b0;
        continue;
      end
      if (dirty_q[s]) begin
        sv = 1'b1;
        sid = tag_q[s];
      end
      return s;
    end
    return -1;
  endfunction

  function automatic rsp_t make_rsp(logic [1:0] st, int idx, logic h);
    rsp_t r;
    r = '0;
    r.status = st;
    r.frame_index = idx[3:0];
    r.hit = h;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void apply_operation(req_t q);
    rsp_t r;
    int f;
    int n;
    logic sv;
    logic [63:0] sid;
    r = '0;
    r.last = 1'b1;
    case (q.operation)
      OP_REQUEST, OP_CREATE: begin
        f = lookup_page(q.operation == OP_CREATE ? q.new_page_id : q.page_id);
        if (f >= 0) begin
          if (q.operation == OP_CREATE) begin
            fixcnt_q[f] = 8'd1;
            dirty_q[f] = 1'b1;
          end else if (fixcnt_q[f] != 8'hFF) begin
            fixcnt_q[f]++;
          end
          mark_q[f] = 1'b1;
          r = make_rsp(ST_OK, f, 1'b1);
        end else begin
          f = claim_frame(sv, sid);
          if (f < 0) begin
            r = make_rsp(ST_NOVICT, 0, 1'b0);
          end else begin
            valid_q[f] = 1'b1;
            tag_q[f] = (q.operation == OP_CREATE) ? q.new_page_id : q.page_id;
            fixcnt_q[f] = 8'd1;
            mark_q[f] = 1'b1;
            dirty_q[f] = (q.operation == OP_CREATE);
            r = make_rsp(ST_OK, f, 1'b0);
            r.load_request = (q.operation == OP_REQUEST);
            r.save_request = sv;
            r.save_page_id = sid;
          end
        end
        expected_rsps.push_back(r);
      end
      OP_DELETE, OP_FIX, OP_UNFIX, OP_DIRTY: begin
        f = lookup_page(q.page_id);
        if (f < 0) begin
          r = make_rsp(ST_ABSENT, 0, 1'b0);
        end else if ((q.operation == OP_DELETE || q.operation == OP_FIX) && fixcnt_q[f] != 0
                     || q.operation == OP_UNFIX && fixcnt_q[f] != 1) begin
          r = make_rsp(ST_FIXRULE, f, 1'b1);
        end else begin
          r = make_rsp(ST_OK, f, 1'b1);
          case (q.operation)
            OP_DELETE: begin
              valid_q[f] = 1'b0;
              fixcnt_q[f] = '0;
              mark_q[f] = 1'b0;
              dirty_q[f] = 1'b0;
              if (used_frames > 0) used_frames--;
              r.drop_request = 1'b1;
            end
            OP_FIX: begin
              fixcnt_q[f] = 8'd1;
              mark_q[f] = 1'b1;
            end
            OP_UNFIX: begin
              fixcnt_q[f] = '0;
              if (q.dirty_flag) dirty_q[f] = 1'b1;
            end
            default: dirty_q[f] = 1'b1;
          endcase
        end
        expected_rsps.push_back(r);
      end
      OP_FLUSH: begin
        n = 0;
        for (int i = 0; i < NFRAMES; i++)
          if (valid_q[i] && dirty_q[i]) begin
            r = make_rsp(ST_OK, i, 1'b0);
            r.save_request = 1'b1;
            r.save_page_id = tag_q[i];
            r.last = 1'b0;
            expected_rsps.push_back(r);
            n++;
          end
        if (n == 0) begin
          r = '0;
          r.last = 1'b1;
          expected_rsps.push_back(r);
        end else begin
          expected_rsps[expected_rsps.size() - 1].last = 1'b1;
        end
      end
      default: expected_rsps.push_back(r);
    endcase
  endfunction

  // Sender: offers queued requests with random idle bursts.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) apply_operation(req_ch.data);
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_ch.data <= pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          if (!quiet && $urandom_range(3) == 0) send_gap = $urandom_range(1, 4);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result in order, stalls at random and holds long when hold_token changes.
  always @(posedge clk) begin
    rsp_t e;
    rsp_t a;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        a = rsp_ch.data;
        if (expected_rsps.size() == 0) begin
          $error("unexpected result: %p", a);
          failures++;
        end else begin
          e = expected_rsps.pop_front();
          if (a.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, a.status); failures++;
          end
          if (a.frame_index !== e.frame_index) begin
            $error("frame_index: expected %0d, actual %0d", e.frame_index, a.frame_index);
            failures++;
          end
          if (a.hit !== e.hit) begin
            $error("hit: expected %0d, actual %0d", e.hit, a.hit); failures++;
          end
          if (a.load_request !== e.load_request) begin
            $error("load_request: expected %0d, actual %0d", e.load_request, a.load_request);
            failures++;
          end
          if (a.save_request !== e.save_request) begin
            $error("save_request: expected %0d, actual %0d", e.save_request, a.save_request);
            failures++;
          end
          if (a.save_page_id !== e.save_page_id) begin
            $error("save_page_id: expected %h, actual %h", e.save_page_id, a.save_page_id);
            failures++;
          end
          if (a.drop_request !== e.drop_request) begin
            $error("drop_request: expected %0d, actual %0d", e.drop_request, a.drop_request);
            failures++;
          end
          if (a.last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, a.last); failures++;
          end
        end
      end
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        recv_gap = 400;
        rsp_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(4) == 0) begin
        recv_gap = $urandom_range(0, 3);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles where neither channel moves while work is outstanding.
  always @(posedge clk) begin
    if (!rst && (req_ch.valid && req_ch.ready || rsp_ch.valid && rsp_ch.ready))
      stall_cycles = 0;
    else if (!rst && (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_ch.valid))
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_FRAME_LIMIT) begin
      limit_reg = value[4:0];
    end else begin
      lfsr_q = (value == 0) ? 16'd1 : value;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_ch.valid);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_op(logic [2:0] op, logic [63:0] pid, logic [63:0] nid, logic d);
    req_t q;
    q.operation = op;
    q.page_id = pid;
    q.new_page_id = nid;
    q.dirty_flag = d;
    pending_reqs.push_back(q);
  endtask

  function automatic logic [63:0] pick_id();
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    return id_pool[$urandom_range(NPOOL - 1)];
  endfunction

  // Request/unfix pairs are the most common pick, so frames cycle through fixed and evictable.
  task automatic queue_random(int count);
    logic [63:0] id;
    int pick;
    for (int k = 0; k < count; k++) begin
      id = pick_id();
      pick = $urandom_range(99);
      if (pick < 30) begin
        queue_op(OP_REQUEST, id, {$urandom, $urandom}, rand_bit());
        queue_op(OP_UNFIX, id, {$urandom, $urandom}, rand_bit());
        k++;
      end else if (pick < 40) queue_op(OP_REQUEST, id, {$urandom, $urandom}, rand_bit());
      else if (pick < 50) queue_op(OP_UNFIX, id, {$urandom, $urandom}, rand_bit());
      else if (pick < 62) queue_op(OP_CREATE, {$urandom, $urandom}, pick_id(), rand_bit());
      else if (pick < 72) queue_op(OP_DELETE, id, {$urandom, $urandom}, rand_bit());
      else if (pick < 81) queue_op(OP_FIX, id, {$urandom, $urandom}, rand_bit());
      else if (pick < 89) queue_op(OP_DIRTY, id, {$urandom, $urandom}, rand_bit());
      else if (pick < 96) queue_op(OP_FLUSH, id, {$urandom, $urandom}, rand_bit());
      else queue_op(OP_IGNORED, id, {$urandom, $urandom}, rand_bit());
    end
  endtask

  initial begin
    for (int i = 0; i < NFRAMES; i++) begin
      tag_q[i] = '0;
      valid_q[i] = 1'b0;
      fixcnt_q[i] = '0;
      mark_q[i] = 1'b0;
      dirty_q[i] = 1'b0;
    end
    used_frames = 0;
    limit_reg = LIMIT_RESET;
    lfsr_q = SEED_RESET;
    for (int i = 0; i < NPOOL; i++) id_pool[i] = {$urandom, $urandom};
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: every operation, absent pages, fix count rule, create hit.
    queue_op(OP_REQUEST, id_pool[0], '1, 1'b0);
    queue_op(OP_REQUEST, id_pool[0], '0, 1'b1);
    queue_op(OP_UNFIX, id_pool[0], '0, 1'b1);
    queue_op(OP_UNFIX, id_pool[0], '0, 1'b0);
    queue_op(OP_UNFIX, id_pool[0], '0, 1'b1);
    queue_op(OP_FIX, id_pool[0], '0, 1'b0);
    queue_op(OP_FIX, id_pool[0], '0, 1'b0);
    queue_op(OP_DELETE, id_pool[0], '0, 1'b0);
    queue_op(OP_UNFIX, id_pool[0], '0, 1'b0);
    queue_op(OP_DELETE, id_pool[0], '0, 1'b0);
    queue_op(OP_DELETE, id_pool[0], '0, 1'b0);
    queue_op(OP_FIX, id_pool[2], '0, 1'b0);
    queue_op(OP_UNFIX, id_pool[2], '0, 1'b1);
    queue_op(OP_DIRTY, id_pool[2], '0, 1'b0);
    queue_op(OP_FLUSH, '0, '0, 1'b0);
    queue_op(OP_CREATE, '0, id_pool[1], 1'b0);
    queue_op(OP_CREATE, '1, id_pool[1], 1'b1);
    queue_op(OP_DIRTY, id_pool[1], '0, 1'b0);
    queue_op(OP_REQUEST, id_pool[3], '0, 1'b0);
    queue_op(OP_FLUSH, '1, '1, 1'b1);
    queue_op(OP_IGNORED, '1, '1, 1'b1);
    wait_drained();

    // Smallest pool: eviction on almost every miss, no victim while fixed.
    write_reg(REG_FRAME_LIMIT, 16'hFFE1);
    write_reg(REG_PROBE_SEED, 16'h0000);
    queue_random(50);
    wait_drained();

    write_reg(REG_FRAME_LIMIT, 16'd4);
    write_reg(REG_PROBE_SEED, 16'hFFFF);
    queue_random(60);
    hold_token++;
    wait_drained();

    write_reg(REG_FRAME_LIMIT, 16'd0);
    write_reg(REG_PROBE_SEED, 16'($urandom_range(1, 65535)));
    queue_random(40);
    wait_drained();

    write_reg(REG_FRAME_LIMIT, {11'($urandom), 5'd31});
    write_reg(REG_PROBE_SEED, 16'($urandom));
    queue_random(60);
    wait_drained();

    write_reg(REG_FRAME_LIMIT, 16'd2);
    queue_random(50);
    wait_drained();

    quiet = 1'b1;
    write_reg(REG_FRAME_LIMIT, 16'd16);
    write_reg(REG_PROBE_SEED, 16'd1);
    queue_random(60);
    wait_drained();
    repeat (60) @(posedge clk);

    if (failures == 0 && expected_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
